### rtl/bka_pkg.sv
// ----------------------------------------------------------------------------
// bka_pkg
// Shared types and constants of the per-core bank allocator.
// ----------------------------------------------------------------------------
package bka_pkg;

    localparam int MAX_CORE_COUNT = 8;
    localparam int CORE_IDX_W     = 3;
    localparam int CORE_CNT_W     = 4;
    localparam int USED_W         = 22;
    localparam int SIZE_W         = 24;
    localparam int OFFSET_W       = 21;

    localparam logic [USED_W-1:0] CORE_MEM_BYTES = 22'd2097152;

    // status codes
    localparam logic [1:0] ST_PLACED   = 2'd0;
    localparam logic [1:0] ST_REJECTED = 2'd1;
    localparam logic [1:0] ST_PARTIAL  = 2'd2;

    // category codes
    localparam logic [1:0] CAT_BASIC = 2'd0;
    localparam logic [1:0] CAT_SMALL = 2'd1;
    localparam logic [1:0] CAT_LARGE = 2'd2;

    // configuration register indexes
    localparam logic CFG_CORES_IN_USE    = 1'b0;
    localparam logic CFG_SPLIT_THRESHOLD = 1'b1;

    typedef struct packed {
        logic [SIZE_W-1:0] size_bytes;
        logic              is_basic;
    } req_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [1:0]            category;
        logic [CORE_IDX_W-1:0] placed_core;
        logic [OFFSET_W-1:0]   base_offset;
        logic [SIZE_W-1:0]     piece_size;
        logic [CORE_CNT_W-1:0] pieces_placed;
        logic [7:0]            overflow_mask;
    } res_t;

    // core bank access port
    typedef struct packed {
        logic [CORE_IDX_W-1:0] rd_idx;
        logic                  wr_en;
        logic [CORE_IDX_W-1:0] wr_idx;
        logic [USED_W-1:0]     wr_data;
    } bank_ctl_t;

endpackage

### rtl/bka_core_bank.sv
// ----------------------------------------------------------------------------
// bka_core_bank
// Bytes-used counters of every core, one read and one write port.
// ----------------------------------------------------------------------------
module bka_core_bank (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bka_pkg::bank_ctl_t            ctl,
    output logic [bka_pkg::USED_W-1:0]    rd_data
);
    import bka_pkg::*;

    logic [USED_W-1:0] used_reg [MAX_CORE_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CORE_COUNT; i++)
            begin
                used_reg[i] <= '0;
            end
        end
        else if (ctl.wr_en)
        begin
            used_reg[ctl.wr_idx] <= ctl.wr_data;
        end
    end

    assign rd_data = used_reg[ctl.rd_idx];

endmodule

### rtl/bka_divider.sv
// ----------------------------------------------------------------------------
// bka_divider
// Restoring divider, one quotient bit per cycle, size by core count.
// ----------------------------------------------------------------------------
module bka_divider (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [bka_pkg::SIZE_W-1:0]        dividend,
    input  logic [bka_pkg::CORE_CNT_W-1:0]    divisor,
    output logic                              done,
    output logic [bka_pkg::SIZE_W-1:0]        quotient,
    output logic                              rem_nz
);
    import bka_pkg::*;

    localparam int CNT_W = $clog2(SIZE_W + 1);

    logic [CNT_W-1:0]      cnt_reg;
    logic                  run_reg;
    logic                  done_reg;
    logic [SIZE_W-1:0]     quo_reg;
    logic [CORE_CNT_W-1:0] rem_reg;
    logic [CORE_CNT_W-1:0] trial;
    logic                  fits;

    // remainder stays below the divisor, at most 8 here, so its top bit is always clear
    assign trial = {rem_reg[CORE_CNT_W-2:0], quo_reg[SIZE_W-1]};
    assign fits  = trial >= divisor;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CNT_W'(SIZE_W);
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[SIZE_W-2:0], fits};
            rem_reg <= fits ? (trial - divisor) : trial;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
    assign rem_nz   = rem_reg != '0;

endmodule

### rtl/per_core_bank_allocator.sv
// ----------------------------------------------------------------------------
// per_core_bank_allocator
// Places allocation requests into the local memories of up to eight cores.
// ----------------------------------------------------------------------------
// Usage:
//   A request (size_bytes, is_basic) is taken on a rising edge with start high
//   and busy low. busy is high from that edge until the cycle that carries
//   the result, in which it is already low again.
//   The result appears on result for one cycle with done high; the receiver
//   must take it then, as there is no back pressure.
//   Steps from the start edge to the result, with n active cores:
//     basic request that fits its round-robin core: try, then done
//     small request: scan of the n cores, try, done; basic fallback: try, scan, try, done
//     distributed request: divide, place pieces over up to n cores, then done
//   One request is in flight at a time; the scan and the placement visit
//   one core per cycle over a single counter read port.
//   cfg_we writes cores_in_use (index 0) or split_threshold (index 1); write
//   only while busy is low and no result is pending.
//   Reset clears all per-core byte counters and the round-robin pointer, sets
//   cores_in_use to 1 and split_threshold to 1024.
// ----------------------------------------------------------------------------
module per_core_bank_allocator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  bka_pkg::req_t               request,
    output logic                        done,
    output bka_pkg::res_t               result,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [bka_pkg::SIZE_W-1:0]  cfg_wdata
);
    import bka_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TRY  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DIST = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]            state_reg;
    logic [CORE_CNT_W-1:0] cores_cfg_reg;
    logic [SIZE_W-1:0]     thresh_reg;
    logic [CORE_IDX_W-1:0] rr_reg;

    logic [SIZE_W-1:0]     size_reg;
    logic                  basic_reg;
    logic [CORE_CNT_W-1:0] n_reg;
    logic [CORE_IDX_W-1:0] core_reg;
    logic [CORE_CNT_W-1:0] scan_reg;
    logic                  found_reg;
    logic [CORE_IDX_W-1:0] best_reg;
    logic [USED_W-1:0]     least_reg;
    logic                  second_reg;
    logic [SIZE_W-1:0]     piece_reg;
    logic [SIZE_W-1:0]     remain_reg;
    logic [CORE_CNT_W-1:0] pieces_reg;
    logic [7:0]            ovf_reg;
    logic [OFFSET_W-1:0]   offset_reg;
    logic [1:0]            status_reg;
    logic [1:0]            cat_reg;
    res_t                  res_reg;
    logic                  done_reg;

    logic [CORE_CNT_W-1:0] n_active;
    bank_ctl_t             bank_ctl;
    logic [USED_W-1:0]     used_rd;
    logic [USED_W-1:0]     room;
    logic [SIZE_W-1:0]     cur_piece;
    logic [SIZE_W-1:0]     cmp_size;
    logic                  fits;
    logic [USED_W-1:0]     slack;
    logic                  better;
    logic                  div_start;
    logic                  div_done;
    logic [SIZE_W-1:0]     div_quo;
    logic                  div_rem_nz;
    logic                  try_ok;
    logic                  dist_more;

    function automatic logic [CORE_IDX_W-1:0] rr_advance(
        input logic [CORE_IDX_W-1:0] rr,
        input logic [CORE_CNT_W-1:0] n
    );
        logic [CORE_CNT_W-1:0] v;
        v = CORE_CNT_W'(rr) + 1'b1;
        // n >= 1 and v <= 8, so eight conditional subtractions reduce it
        for (int i = 0; i < MAX_CORE_COUNT; i++)
        begin
            if (v >= n)
            begin
                v = v - n;
            end
        end
        return v[CORE_IDX_W-1:0];
    endfunction

    always_comb
    begin
        if (cores_cfg_reg == '0)
        begin
            n_active = CORE_CNT_W'(1);
        end
        else if (cores_cfg_reg > CORE_CNT_W'(MAX_CORE_COUNT))
        begin
            n_active = CORE_CNT_W'(MAX_CORE_COUNT);
        end
        else
        begin
            n_active = cores_cfg_reg;
        end
    end

    // shared room check against the selected core
    assign cur_piece = (piece_reg < remain_reg) ? piece_reg : remain_reg;
    assign cmp_size  = (state_reg == S_DIST) ? cur_piece : size_reg;
    assign room      = CORE_MEM_BYTES - used_rd;
    assign fits      = {2'b00, room} >= cmp_size;
    assign slack     = room - cmp_size[USED_W-1:0];
    assign better    = fits && (!found_reg || slack < least_reg);
    assign try_ok    = (CORE_CNT_W'(core_reg) < n_reg) && fits;
    assign dist_more = (scan_reg < n_reg) && (remain_reg != '0);

    always_comb
    begin
        bank_ctl.rd_idx  = (state_reg == S_TRY) ? core_reg : scan_reg[CORE_IDX_W-1:0];
        bank_ctl.wr_idx  = bank_ctl.rd_idx;
        bank_ctl.wr_data = used_rd + cmp_size[USED_W-1:0];
        bank_ctl.wr_en   = ((state_reg == S_TRY) && try_ok)
                        || ((state_reg == S_DIST) && dist_more && fits);
    end

    assign div_start = (state_reg == S_IDLE) && start && !request.is_basic
                    && (request.size_bytes >= thresh_reg);

    bka_core_bank u_bank (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (bank_ctl),
        .rd_data (used_rd)
    );

    bka_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (request.size_bytes),
        .divisor  (n_active),
        .done     (div_done),
        .quotient (div_quo),
        .rem_nz   (div_rem_nz)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cores_cfg_reg <= CORE_CNT_W'(1);
            thresh_reg    <= SIZE_W'(1024);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CORES_IN_USE:    cores_cfg_reg <= cfg_wdata[CORE_CNT_W-1:0];
                CFG_SPLIT_THRESHOLD: thresh_reg    <= cfg_wdata;
                default:             ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rr_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        if (request.is_basic)
                        begin
                            rr_reg    <= rr_advance(rr_reg, n_active);
                            state_reg <= S_TRY;
                        end
                        else if (request.size_bytes < thresh_reg)
                        begin
                            state_reg <= S_SCAN;
                        end
                        else
                        begin
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_TRY:
                begin
                    if (!try_ok && basic_reg && !second_reg)
                    begin
                        state_reg <= S_SCAN;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_SCAN:
                begin
                    if (scan_reg == n_reg - 1'b1)
                    begin
                        state_reg <= S_TRY;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_DIST;
                    end
                end
                S_DIST:
                begin
                    if (!dist_more)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // request datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                size_reg   <= request.size_bytes;
                basic_reg  <= request.is_basic;
                n_reg      <= n_active;
                core_reg   <= rr_reg;
                scan_reg   <= '0;
                found_reg  <= 1'b0;
                best_reg   <= '0;
                least_reg  <= '0;
                second_reg <= !request.is_basic;
                piece_reg  <= request.size_bytes;
                remain_reg <= request.size_bytes;
                pieces_reg <= '0;
                ovf_reg    <= '0;
                offset_reg <= '0;
                status_reg <= ST_PLACED;
                if (request.is_basic)
                begin
                    cat_reg <= CAT_BASIC;
                end
                else if (request.size_bytes < thresh_reg)
                begin
                    cat_reg <= CAT_SMALL;
                end
                else
                begin
                    cat_reg <= CAT_LARGE;
                end
            end
            S_TRY:
            begin
                if (try_ok)
                begin
                    pieces_reg <= CORE_CNT_W'(1);
                    offset_reg <= used_rd[OFFSET_W-1:0];
                end
                else if (basic_reg && !second_reg)
                begin
                    second_reg <= 1'b1;
                end
                else
                begin
                    status_reg <= ST_REJECTED;
                    ovf_reg    <= 8'(1) << core_reg;
                end
            end
            S_SCAN:
            begin
                if (better)
                begin
                    found_reg <= 1'b1;
                    best_reg  <= scan_reg[CORE_IDX_W-1:0];
                    least_reg <= slack;
                end
                if (scan_reg == n_reg - 1'b1)
                begin
                    // no fitting core leaves the best pick at core 0
                    core_reg <= better ? scan_reg[CORE_IDX_W-1:0] : best_reg;
                end
                else
                begin
                    scan_reg <= scan_reg + 1'b1;
                end
            end
            S_DIV:
            begin
                core_reg <= '0;
                if (div_done)
                begin
                    piece_reg <= div_quo + SIZE_W'(div_rem_nz);
                end
            end
            S_DIST:
            begin
                if (dist_more)
                begin
                    if (fits)
                    begin
                        pieces_reg <= pieces_reg + 1'b1;
                        remain_reg <= remain_reg - cur_piece;
                        if (scan_reg == '0)
                        begin
                            offset_reg <= used_rd[OFFSET_W-1:0];
                        end
                    end
                    else
                    begin
                        ovf_reg <= ovf_reg | (8'(1) << scan_reg[CORE_IDX_W-1:0]);
                    end
                    scan_reg <= scan_reg + 1'b1;
                end
                else
                begin
                    status_reg <= (remain_reg == '0) ? ST_PLACED : ST_PARTIAL;
                end
            end
            S_DONE:
            begin
                res_reg.status        <= status_reg;
                res_reg.category      <= cat_reg;
                res_reg.placed_core   <= core_reg;
                res_reg.base_offset   <= offset_reg;
                res_reg.piece_size    <= piece_reg;
                res_reg.pieces_placed <= pieces_reg;
                res_reg.overflow_mask <= ovf_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign busy   = state_reg != S_IDLE;
    assign done   = done_reg;
    assign result = res_reg;

endmodule

### dv/per_core_bank_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// per_core_bank_allocator_tb
// Self-checking bench for the per-core bank allocator. A queue of requests
// and register writes feeds a falling-edge driver. A rising-edge monitor
// predicts each accepted request against its own copy of the per-core usage
// and compares every result field by field.
// ----------------------------------------------------------------------------
module per_core_bank_allocator_tb;

    import bka_pkg::*;

    localparam int LIMIT  = 2_000_000;
    localparam int DRAIN  = 80;
    localparam int PHASES = 11;
    localparam int PHASE_ITEMS = 103;

    typedef struct {
        bit                is_cfg;
        logic              cfg_idx;
        logic [SIZE_W-1:0] cfg_data;
        req_t              req;
        int                gap;
    } drv_item_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    req_t              request = '0;
    logic              done;
    res_t              result;
    logic              cfg_we = 1'b0;
    logic              cfg_index = CFG_CORES_IN_USE;
    logic [SIZE_W-1:0] cfg_wdata = '0;

    per_core_bank_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // predicted allocator state
    logic [USED_W-1:0]     bank_used [MAX_CORE_COUNT] = '{default: '0};
    logic [CORE_IDX_W-1:0] rr_core    = '0;
    logic [3:0]            cfg_cores  = 4'd1;
    logic [SIZE_W-1:0]     cfg_thresh = 24'd1024;

    drv_item_t pending_items [$];
    res_t      expected_results [$];

    bit          calm = 1'b0;
    int          gap_left = 0;
    int unsigned n_issued = 0;
    int unsigned n_accepted = 0;
    int unsigned n_results = 0;
    int unsigned n_errors = 0;
    int unsigned n_cfg_writes = 0;
    int unsigned n_split = 0;
    int unsigned n_rejected = 0;
    int unsigned n_partial = 0;
    int unsigned cycles = 0;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic bit claim(int unsigned n, int unsigned c, int unsigned sz);
        int unsigned room;
        if (c >= n)
            return 1'b0;
        room = 32'(CORE_MEM_BYTES) - 32'(bank_used[c]);
        if (room < sz)
            return 1'b0;
        bank_used[c] = bank_used[c] + USED_W'(sz);
        return 1'b1;
    endfunction

    // fitting core with the least room left over, core 0 when none fits
    function automatic int unsigned best_fit(int unsigned n, int unsigned sz);
        int unsigned best, least, room;
        best  = 0;
        least = 32'hFFFF_FFFF;
        for (int unsigned c = 0; c < n; c++)
        begin
            room = 32'(CORE_MEM_BYTES) - 32'(bank_used[c]);
            if (room >= sz && room - sz < least)
            begin
                least = room - sz;
                best  = c;
            end
        end
        return best;
    endfunction

    function automatic res_t place_request(req_t rq);
        int unsigned n, sz, core, piece, left, cur;
        bit          ok;
        res_t        r;
        n = 32'(cfg_cores);
        if (n == 0)
            n = 1;
        if (n > MAX_CORE_COUNT)
            n = MAX_CORE_COUNT;
        sz = 32'(rq.size_bytes);
        r = '0;
        r.status = ST_PLACED;
        r.piece_size = rq.size_bytes;
        if (rq.is_basic || sz < cfg_thresh)
        begin
            if (rq.is_basic)
            begin
                r.category = CAT_BASIC;
                core = 32'(rr_core);
                rr_core = CORE_IDX_W'((32'(rr_core) + 1) % n);
                ok = claim(n, core, sz);
                if (!ok)
                begin
                    // round-robin core full or stale, fall back to best fit
                    core = best_fit(n, sz);
                    ok = claim(n, core, sz);
                end
            end
            else
            begin
                r.category = CAT_SMALL;
                core = best_fit(n, sz);
                ok = claim(n, core, sz);
            end
            r.placed_core = CORE_IDX_W'(core);
            if (ok)
            begin
                r.pieces_placed = CORE_CNT_W'(1);
                r.base_offset = OFFSET_W'(32'(bank_used[core]) - sz);
            end
            else
            begin
                r.status = ST_REJECTED;
                r.overflow_mask = 8'(1 << core);
            end
        end
        else
        begin
            r.category = CAT_LARGE;
            piece = sz / n + ((sz % n) != 0 ? 1 : 0);
            r.piece_size = SIZE_W'(piece);
            left = sz;
            for (int unsigned c = 0; c < n && left > 0; c++)
            begin
                cur = (piece < left) ? piece : left;
                if (claim(n, c, cur))
                begin
                    r.pieces_placed = r.pieces_placed + 1'b1;
                    left = left - cur;
                    if (c == 0)
                        r.base_offset = OFFSET_W'(32'(bank_used[0]) - piece);
                end
                else
                begin
                    r.overflow_mask = r.overflow_mask | 8'(1 << c);
                end
            end
            r.status = (left == 0) ? ST_PLACED : ST_PARTIAL;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        n_errors++;
        $display("mismatch on result %0d: %s got 0x%0h expected 0x%0h",
                 n_results, what, got, want);
    endtask

    task automatic check_result(res_t got, res_t want);
        if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
        if (got.category !== want.category)
            report_mismatch("category", got.category, want.category);
        if (got.placed_core !== want.placed_core)
            report_mismatch("placed_core", got.placed_core, want.placed_core);
        if (got.base_offset !== want.base_offset)
            report_mismatch("base_offset", got.base_offset, want.base_offset);
        if (got.piece_size !== want.piece_size)
            report_mismatch("piece_size", got.piece_size, want.piece_size);
        if (got.pieces_placed !== want.pieces_placed)
            report_mismatch("pieces_placed", got.pieces_placed, want.pieces_placed);
        if (got.overflow_mask !== want.overflow_mask)
            report_mismatch("overflow_mask", got.overflow_mask, want.overflow_mask);
    endtask

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int k;
        if (calm)
            return 0;
        k = $urandom_range(0, 99);
        if (k < 40)
            return 0;
        if (k < 80)
            return $urandom_range(1, 3);
        if (k < 95)
            return $urandom_range(4, 20);
        return $urandom_range(50, 300);
    endfunction

    task automatic queue_request(int unsigned size, bit basic);
        drv_item_t it;
        it = '{default: '0};
        it.req.size_bytes = SIZE_W'(size);
        it.req.is_basic   = basic;
        it.gap = pick_gap();
        pending_items.push_back(it);
    endtask

    task automatic queue_config(logic idx, logic [SIZE_W-1:0] data);
        drv_item_t it;
        it = '{default: '0};
        it.is_cfg   = 1'b1;
        it.cfg_idx  = idx;
        it.cfg_data = data;
        it.gap = pick_gap();
        pending_items.push_back(it);
    endtask

    // mostly small sizes so memory fills gradually; full range only when heavy
    function automatic int unsigned draw_size(bit heavy);
        int k;
        if (heavy && $urandom_range(0, 99) < 15)
            return $urandom() & 32'hFF_FFFF;
        k = $urandom_range(0, 99);
        if (k < 4)
            return 0;
        if (k < 50)
            return $urandom_range(0, 63);
        if (k < 80)
            return $urandom_range(64, 4095);
        if (k < 98)
            return $urandom_range(4096, 65535);
        return $urandom_range(65536, 1 << 20);
    endfunction

    function automatic logic [SIZE_W-1:0] draw_threshold();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 24'd1;
            2: return 24'hFF_FFFF;
            5: return SIZE_W'($urandom());
            default: return SIZE_W'($urandom_range(16, 8192));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : drive
        drv_item_t         it;
        logic              nxt_start;
        logic              nxt_we;
        logic              nxt_idx;
        logic [SIZE_W-1:0] nxt_data;
        req_t              nxt_req;
        nxt_start = start;
        nxt_req   = request;
        nxt_we    = 1'b0;
        nxt_idx   = cfg_index;
        nxt_data  = cfg_wdata;
        if (!rst_n)
        begin
            nxt_start = 1'b0;
        end
        else
        begin
            if (start && n_accepted == n_issued)
                nxt_start = 1'b0;
            if (!nxt_start)
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                end
                else if (pending_items.size() > 0)
                begin
                    it = pending_items[0];
                    if (!it.is_cfg)
                    begin
                        nxt_start = 1'b1;
                        nxt_req   = it.req;
                        n_issued++;
                        gap_left = it.gap;
                        void'(pending_items.pop_front());
                    end
                    else if (expected_results.size() == 0 && !busy && !start)
                    begin
                        // register writes only while the allocator is idle
                        nxt_we   = 1'b1;
                        nxt_idx  = it.cfg_idx;
                        nxt_data = it.cfg_data;
                        gap_left = it.gap;
                        void'(pending_items.pop_front());
                    end
                end
            end
        end
        start     <= nxt_start;
        request   <= nxt_req;
        cfg_we    <= nxt_we;
        cfg_index <= nxt_idx;
        cfg_wdata <= nxt_data;
    end

    // ------------------------------------------------------------------
    // monitor
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watch
        res_t want;
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                n_results++;
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result", 0, 0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_result(result, want);
                end
            end
            if (cfg_we)
            begin
                n_cfg_writes++;
                if (cfg_index == CFG_CORES_IN_USE)
                    cfg_cores = cfg_wdata[3:0];
                else
                    cfg_thresh = cfg_wdata;
            end
            if (start && !busy)
            begin
                want = place_request(request);
                if (want.category == CAT_LARGE)
                    n_split++;
                if (want.status == ST_REJECTED)
                    n_rejected++;
                if (want.status == ST_PARTIAL)
                    n_partial++;
                expected_results.push_back(want);
                n_accepted++;
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycles++;
        if (cycles >= LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin : sequence_main
        int cores_plan [PHASES];
        cores_plan = '{8, 1, 4, 15, 2, 0, 8, 3, 6, 7, 5};

        // after reset: one core, threshold 1024
        queue_request(0, 1'b1);
        queue_request(24'hFF_FFFF, 1'b1);
        queue_request(1023, 1'b0);
        queue_request(1024, 1'b0);
        queue_request(0, 1'b0);
        queue_request(24'hFF_FFFF, 1'b0);

        // core count zero acts as one, zero threshold splits every non-basic request
        queue_config(CFG_CORES_IN_USE, 24'h0);
        queue_config(CFG_SPLIT_THRESHOLD, 24'h0);
        queue_request(0, 1'b0);
        queue_request(5, 1'b0);
        queue_request(7, 1'b1);

        // core count above the maximum saturates
        queue_config(CFG_CORES_IN_USE, 24'hFF_FFFF);
        queue_config(CFG_SPLIT_THRESHOLD, 24'h1);
        queue_request(0, 1'b0);
        queue_request(17, 1'b0);
        for (int i = 0; i < 6; i++)
            queue_request(4 * (i + 1), 1'b1);

        // pointer now stale for three cores
        queue_config(CFG_CORES_IN_USE, 24'h3);
        queue_config(CFG_SPLIT_THRESHOLD, 24'hFF_FFFF);
        queue_request(100, 1'b1);
        queue_request(24'hFF_FFFE, 1'b0);
        queue_request(2000, 1'b0);
        queue_request(24'h1F_FFFF, 1'b1);
        queue_request(24'hAA_AAAA, 1'b1);
        queue_request(24'h55_5555, 1'b1);
        queue_request(24'h0A_AAAA, 1'b0);

        for (int p = 0; p < PHASES; p++)
        begin
            calm = (p % 4 == 1);
            queue_config(CFG_CORES_IN_USE,
                         {20'($urandom()), 4'(cores_plan[p])});
            queue_config(CFG_SPLIT_THRESHOLD, draw_threshold());
            for (int i = 0; i < PHASE_ITEMS; i++)
                queue_request(draw_size(p >= PHASES - 2), $urandom_range(0, 99) < 40);
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || start || n_accepted != n_issued)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("%0d requests checked: %0d split, %0d rejected, %0d split short",
                 n_results, n_split, n_rejected, n_partial);
        $display("%0d register writes across %0d core-count settings, %0d mismatches",
                 n_cfg_writes, PHASES + 4, n_errors);
        if (n_errors == 0 && expected_results.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
